FILE: src/ccwa_pkg.sv
// Shared types, constants and calendar functions for the calendar clock with alarm.
package ccwa_pkg;

    // Configuration port geometry and register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOUR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MINUTE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_SECOND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMID_LIMIT  = 3'd4;

    // Counter limits
    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [5:0] MIN_MAX   = 6'd59;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [4:0] HOUR_HALF = 5'd12;
    localparam logic [3:0] MONTH_MAX = 4'd12;

    // Reset date and time: 2021-11-17 10:00:00
    localparam logic [11:0] RST_YEAR   = 12'd2021;
    localparam logic [3:0]  RST_MONTH  = 4'd11;
    localparam logic [4:0]  RST_DAY    = 5'd17;
    localparam logic [4:0]  RST_HOUR   = 5'd10;
    localparam logic [5:0]  RST_MINUTE = 6'd0;
    localparam logic [5:0]  RST_SECOND = 6'd0;

    localparam logic [7:0]  RST_LIMIT  = 8'd255;

    // Reciprocal of 25 in 16 fractional bits; exact floor for every 12-bit year
    localparam logic [11:0] RECIP_25   = 12'd2622;

    typedef struct packed {
        logic        twelve_hour_mode;
        logic [7:0]  temperature;
        logic [7:0]  humidity_now;
    } t_in_word;

    typedef struct packed {
        logic [11:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic        pm_flag;
        logic        hour_chime;
        logic        alarm_hit;
        logic [1:0]  env_level;
    } t_out_word;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_time;

    typedef struct packed {
        logic [4:0]  alarm_hour;
        logic [5:0]  alarm_minute;
        logic [5:0]  alarm_second;
        logic [7:0]  temp_limit;
        logic [7:0]  humid_limit;
    } t_cfg;

    // Gregorian leap rule; year 0 counts as leap
    function automatic logic is_leap(input logic [11:0] year);
        logic [23:0] prod;
        logic [7:0]  quot;
        logic [11:0] rem;
        logic        div4;
        logic        div100;
        logic        div400;
        prod   = year * RECIP_25;
        quot   = prod[23:16];
        rem    = year - (12'(quot) * 12'd25);
        div4   = (year[1:0] == 2'd0);
        div100 = div4 && (rem == 12'd0);
        div400 = div100 && (year[3:0] == 4'd0);
        return div4 && (!div100 || div400);
    endfunction

    // Month length; out-of-range months fold onto the month of their low bits mod 12
    function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        unique case (month)
            4'd2, 4'd14:              len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: src/ccwa_time.sv
// Next-state cascade for seconds, minutes, hours and the calendar date.
module ccwa_time (
    input  ccwa_pkg::t_time i_cur,
    output ccwa_pkg::t_time o_next,
    output logic            o_chime
);
    import ccwa_pkg::*;

    logic [4:0] days_now;

    assign days_now = days_in_month(i_cur.month, is_leap(i_cur.year));

    always_comb begin
        o_next  = i_cur;
        o_chime = 1'b0;
        if (i_cur.second < SEC_MAX) begin
            o_next.second = i_cur.second + 6'd1;
        end else begin
            o_next.second = 6'd0;
            if (i_cur.minute < MIN_MAX) begin
                o_next.minute = i_cur.minute + 6'd1;
            end else begin
                o_next.minute = 6'd0;
                o_chime       = 1'b1;
                if (i_cur.hour < HOUR_MAX) begin
                    o_next.hour = i_cur.hour + 5'd1;
                end else begin
                    o_next.hour = 5'd0;
                    if (i_cur.day < days_now) begin
                        o_next.day = i_cur.day + 5'd1;
                    end else begin
                        o_next.day = 5'd1;
                        if (i_cur.month < MONTH_MAX) begin
                            o_next.month = i_cur.month + 4'd1;
                        end else begin
                            o_next.month = 4'd1;
                            o_next.year  = i_cur.year + 12'd1;
                        end
                    end
                end
            end
        end
    end

endmodule

FILE: src/ccwa_disp.sv
// Display mapping, alarm match and environment level for one result word.
module ccwa_disp (
    input  ccwa_pkg::t_time     i_time,
    input  logic                i_chime,
    input  ccwa_pkg::t_in_word  i_in,
    input  ccwa_pkg::t_cfg      i_cfg,
    output ccwa_pkg::t_out_word o_word
);
    import ccwa_pkg::*;

    logic pm;
    logic temp_hit;
    logic humid_hit;

    assign pm        = (i_time.hour >= HOUR_HALF);
    assign temp_hit  = (i_in.temperature  >= i_cfg.temp_limit);
    assign humid_hit = (i_in.humidity_now >= i_cfg.humid_limit);

    always_comb begin
        o_word.year_out   = i_time.year;
        o_word.month_out  = i_time.month;
        o_word.day_out    = i_time.day;
        o_word.minute_out = i_time.minute;
        o_word.second_out = i_time.second;
        o_word.pm_flag    = pm;
        o_word.hour_chime = i_chime;
        // fold afternoon hours onto 0-11 in 12-hour form
        o_word.hour_out   = (i_in.twelve_hour_mode && pm) ? (i_time.hour - HOUR_HALF)
                                                          : i_time.hour;
        o_word.alarm_hit  = !i_in.twelve_hour_mode
                            && (i_time.hour   == i_cfg.alarm_hour)
                            && (i_time.minute == i_cfg.alarm_minute)
                            && (i_time.second == i_cfg.alarm_second);
        o_word.env_level  = {1'b0, temp_hit} + {1'b0, humid_hit};
    end

endmodule

FILE: src/calendar_clock_with_alarm.sv
// Calendar clock with alarm: top level with time state, alarm registers and result register.
// A result word appears in the cycle after its tick word is accepted.
// Throughput: one tick word per cycle while results are taken; the single cascade from
//   time register through the next-state and display logic to the result register sets this.
// A new word is taken while the previous result waits, as long as the result is taken too.
// Reset (synchronous, active low): 2021-11-17 10:00:00, alarm 00:00:00, limits 255, no result.
module calendar_clock_with_alarm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ccwa_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ccwa_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ccwa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ccwa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ccwa_pkg::*;

    t_time     r_time;
    t_time     n_time;
    t_cfg      r_cfg;
    t_out_word r_out;
    t_out_word n_out;
    logic      r_out_valid;
    logic      chime;
    logic      in_take;

    // Accept a new tick whenever the result register is empty or being drained
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_take     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Advance the time by one second
    ccwa_time u_time (
        .i_cur   (r_time),
        .o_next  (n_time),
        .o_chime (chime)
    );

    // Build the result word from the advanced time
    ccwa_disp u_disp (
        .i_time  (n_time),
        .i_chime (chime),
        .i_in    (i_in_word),
        .i_cfg   (r_cfg),
        .o_word  (n_out)
    );

    // Alarm and limit registers; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_hour   <= 5'd0;
            r_cfg.alarm_minute <= 6'd0;
            r_cfg.alarm_second <= 6'd0;
            r_cfg.temp_limit   <= RST_LIMIT;
            r_cfg.humid_limit  <= RST_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ALARM_HOUR:   r_cfg.alarm_hour   <= i_cfg_data[4:0];
                CFG_ALARM_MINUTE: r_cfg.alarm_minute <= i_cfg_data[5:0];
                CFG_ALARM_SECOND: r_cfg.alarm_second <= i_cfg_data[5:0];
                CFG_TEMP_LIMIT:   r_cfg.temp_limit   <= i_cfg_data;
                CFG_HUMID_LIMIT:  r_cfg.humid_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Time of day and date; advance once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time.year   <= RST_YEAR;
            r_time.month  <= RST_MONTH;
            r_time.day    <= RST_DAY;
            r_time.hour   <= RST_HOUR;
            r_time.minute <= RST_MINUTE;
            r_time.second <= RST_SECOND;
        end else if (in_take) begin
            r_time <= n_time;
        end
    end

    // Result register valid flag: set on a tick, clear when the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: src/ccwa_checker.sv
// Port-level checks for the calendar clock with alarm, bound to the top level.
module ccwa_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input ccwa_pkg::t_out_word   i_out_word
);
    import ccwa_pkg::*;

    // Result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("result word changed or dropped while stalled");

    // Every accepted tick gives a result next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted tick produced no result");

    // Chime only on the top of an hour
    a_chime_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.hour_chime |->
            i_out_word.minute_out == 6'd0 && i_out_word.second_out == 6'd0)
        else $error("chime away from the top of the hour");

    // Alarm only in 24-hour form, where the PM flag follows the shown hour
    a_alarm_24h: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.alarm_hit |->
            i_out_word.pm_flag == (i_out_word.hour_out >= HOUR_HALF))
        else $error("alarm flagged with 12-hour display");

    // Never more than two limits
    a_env_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_word.env_level != 2'd3)
        else $error("environment level out of range");

endmodule

bind calendar_clock_with_alarm ccwa_checker u_ccwa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_word  (o_out_word)
);

FILE: test/tb.sv
// Testbench for the calendar clock with alarm: random and directed ticks against a predictor.
`timescale 1ns / 1ps

module tb;
    import ccwa_pkg::*;

    // Predict the calendar and time that each tick word should produce, and hold those
    // words until the block hands its results back.
    class clock_scoreboard;
        t_time      clk_now;
        t_cfg       regs;
        t_out_word  due_words[$];
        int unsigned errors;

        function new();
            clk_now = '{year: 12'd2021, month: 4'd11, day: 5'd17,
                        hour: 5'd10, minute: 6'd0, second: 6'd0};
            regs    = '{alarm_hour: 5'd0, alarm_minute: 6'd0, alarm_second: 6'd0,
                        temp_limit: 8'd255, humid_limit: 8'd255};
            errors  = 0;
        endfunction

        function int unsigned pending();
            return due_words.size();
        endfunction

        // Fold any month code onto a calendar month, then apply the Gregorian leap rule
        function int unsigned days_in(int unsigned yr, int unsigned mon);
            int unsigned slot;
            bit          leap;
            slot = (mon == 0) ? 11 : (mon - 1) % 12;
            leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
            case (slot)
                1:          return leap ? 29 : 28;
                3, 5, 8, 10: return 30;
                default:    return 31;
            endcase
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ALARM_HOUR:   regs.alarm_hour   = data[4:0];
                CFG_ALARM_MINUTE: regs.alarm_minute = data[5:0];
                CFG_ALARM_SECOND: regs.alarm_second = data[5:0];
                CFG_TEMP_LIMIT:   regs.temp_limit   = data;
                CFG_HUMID_LIMIT:  regs.humid_limit  = data;
                default: ;
            endcase
        endfunction

        // Time of day k seconds from the current predicted time
        function t_time time_ahead(int unsigned k);
            int unsigned secs;
            t_time       t;
            secs = (clk_now.hour * 3600 + clk_now.minute * 60 + clk_now.second + k) % 86400;
            t = clk_now;
            t.hour   = 5'(secs / 3600);
            t.minute = 6'((secs / 60) % 60);
            t.second = 6'(secs % 60);
            return t;
        endfunction

        function void note_tick(t_in_word w);
            int unsigned s, m, h, d, mo, y, env;
            t_out_word   r;
            bit          chime;
            s  = clk_now.second + 1;
            m  = clk_now.minute;
            h  = clk_now.hour;
            d  = clk_now.day;
            mo = clk_now.month;
            y  = clk_now.year;
            chime = 1'b0;
            // Cascade the carry up through the counters
            if (s > 59) begin
                s = 0;
                m++;
                if (m > 59) begin
                    m = 0;
                    h++;
                    chime = 1'b1;
                    if (h > 23) begin
                        h = 0;
                        d++;
                        if (d > days_in(y, mo)) begin
                            d = 1;
                            mo++;
                            if (mo > 12) begin
                                mo = 1;
                                y  = (y + 1) % 4096;
                            end
                        end
                    end
                end
            end
            clk_now = '{year: 12'(y), month: 4'(mo), day: 5'(d),
                        hour: 5'(h), minute: 6'(m), second: 6'(s)};
            env = 0;
            if (w.temperature >= regs.temp_limit) env++;
            if (w.humidity_now >= regs.humid_limit) env++;
            r.year_out   = clk_now.year;
            r.month_out  = clk_now.month;
            r.day_out    = clk_now.day;
            r.hour_out   = w.twelve_hour_mode ? 5'(h % 12) : clk_now.hour;
            r.minute_out = clk_now.minute;
            r.second_out = clk_now.second;
            r.pm_flag    = (h >= 12);
            r.hour_chime = chime;
            r.alarm_hit  = !w.twelve_hour_mode && clk_now.hour == regs.alarm_hour &&
                           clk_now.minute == regs.alarm_minute &&
                           clk_now.second == regs.alarm_second;
            r.env_level  = 2'(env);
            due_words.push_back(r);
        endfunction

        function void cmp(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (due_words.size() == 0) begin
                $error("result word with no tick waiting for it");
                errors++;
                return;
            end
            want = due_words.pop_front();
            cmp("year_out",   want.year_out,   got.year_out);
            cmp("month_out",  want.month_out,  got.month_out);
            cmp("day_out",    want.day_out,    got.day_out);
            cmp("hour_out",   want.hour_out,   got.hour_out);
            cmp("minute_out", want.minute_out, got.minute_out);
            cmp("second_out", want.second_out, got.second_out);
            cmp("pm_flag",    want.pm_flag,    got.pm_flag);
            cmp("hour_chime", want.hour_chime, got.hour_chime);
            cmp("alarm_hit",  want.alarm_hit,  got.alarm_hit);
            cmp("env_level",  want.env_level,  got.env_level);
        endfunction
    endclass

    // Every input holds a known value from time zero; reset stays low until released
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    t_in_word                i_in_word   = '0;
    logic                    i_out_ready = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    t_out_word               o_out_word;
    logic                    o_cfg_ready;

    clock_scoreboard         sb;
    int unsigned             send_idle_pct = 0;
    int unsigned             out_stall_pct = 0;

    calendar_clock_with_alarm dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Stall the result side at the rate the current phase asks for
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Watch all three channels; values read here are those from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) sb.note_tick(i_in_word);
            if (o_out_valid && i_out_ready) sb.check_word(o_out_word);
        end
    end

    // Offer one tick word, hold it until taken, then perhaps leave the channel idle
    task automatic push_tick(input t_in_word w);
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
    endtask

    // Keep the write valid across back-to-back register writes; the caller drops it
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Write all five registers, then one unused index above them that must change nothing
    task automatic set_regs(input logic [7:0] a_hr, input logic [7:0] a_min,
                            input logic [7:0] a_sec, input logic [7:0] t_lim,
                            input logic [7:0] h_lim);
        cfg_write(CFG_ALARM_HOUR, a_hr);
        cfg_write(CFG_ALARM_MINUTE, a_min);
        cfg_write(CFG_ALARM_SECOND, a_sec);
        cfg_write(CFG_TEMP_LIMIT, t_lim);
        cfg_write(CFG_HUMID_LIMIT, h_lim);
        cfg_write(CFG_HUMID_LIMIT + CFG_IDX_W'($urandom_range(3, 1)), 8'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop the tick channel, let the last accepted tick be noted, then wait until every
    // outstanding word has been checked, and let the clock run on before returning
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_limit();
        case ($urandom_range(2))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        t_in_word w;
        t_time    al;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, first half: alarm at 10:00:03 written through over-wide register
        // values (upper bits dropped), temperature limit in mid range, humidity at top.
        // The third tick lands on the alarm in 24-hour mode; the rest step through the
        // extremes of both readings and flip the display mode.
        set_regs(8'hEA, 8'hC0, 8'h03, 8'h80, 8'hFF);
        for (int i = 0; i < 12; i++) begin
            w.twelve_hour_mode = (i == 2) ? 1'b0 : 1'(i % 2);
            case (i % 4)
                0:       w.temperature = 8'h00;
                1:       w.temperature = 8'hFF;
                2:       w.temperature = 8'h7F;
                default: w.temperature = 8'h80;
            endcase
            w.humidity_now = (i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : 8'hAA);
            push_tick(w);
        end
        drain();

        // Directed, second half: alarm four seconds ahead, but that tick comes in
        // 12-hour mode so the match must stay quiet; both limits at zero.
        al = sb.time_ahead(4);
        set_regs(8'(al.hour), 8'(al.minute), 8'(al.second), 8'h00, 8'h00);
        for (int i = 0; i < 8; i++) begin
            w.twelve_hour_mode = (i == 3);
            w.temperature      = 8'($urandom);
            w.humidity_now     = 8'($urandom);
            push_tick(w);
        end
        drain();

        // Random phases with the idling mix changing each time; alarm set somewhere
        // inside the coming stretch, except one phase where it can never match.
        for (int p = 0; p < 5; p++) begin
            case (p)
                1:       begin send_idle_pct = 65; out_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  out_stall_pct = 65; end
                3:       begin send_idle_pct = 27; out_stall_pct = 27; end
                default: begin send_idle_pct = 0;  out_stall_pct = 0;  end
            endcase
            if (p == 3) begin
                set_regs(8'hFF, 8'($urandom_range(63, 60)), 8'($urandom_range(63)),
                         pick_limit(), pick_limit());
            end else begin
                al = sb.time_ahead($urandom_range(240, 5));
                set_regs(8'(al.hour), 8'(al.minute), 8'(al.second),
                         pick_limit(), pick_limit());
            end
            for (int i = 0; i < 250; i++) begin
                w.twelve_hour_mode = ($urandom_range(3) == 0);
                w.temperature      = 8'($urandom);
                w.humidity_now     = 8'($urandom);
                push_tick(w);
            end
            drain();
        end

        send_idle_pct = 0;
        out_stall_pct = 0;
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest honest run
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
